// ===== hdl/r2a_pkg.sv =====
`default_nettype none
package r2a_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int FIELD_BITS     = 32;
  localparam int DIGIT_BITS     = 6;
  localparam int CHAR_BITS      = 8;

  localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [DIGIT_BITS-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 6'd10;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_BITS-1:0]  CHAR_A      = 8'h41;
  localparam logic [CHAR_BITS-1:0]  CHAR_NONE   = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } conv_state_t;

  // Divider report at the end of each digit
  typedef struct packed {
    logic                  done;
    logic                  quo_zero;
    logic [DIGIT_BITS-1:0] digit;
  } div_status_t;

  function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {2'b00, d};
    end else begin
      c = CHAR_A + {2'b00, d} - {2'b00, DIGIT_TEN};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/r2a_divider.sv =====
`default_nettype none
module r2a_divider
  import r2a_pkg::*;
#(
  parameter int WIDTH = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic [WIDTH-1:0]      operand,
  input  wire logic [DIGIT_BITS-1:0] radix,
  output div_status_t                status
);

  localparam int BW = $clog2(WIDTH);

  logic [WIDTH-1:0]      quo;
  logic [WIDTH-1:0]      quo_next;
  logic [DIGIT_BITS-1:0] rem;
  logic [DIGIT_BITS-1:0] rem_next;
  logic [BW-1:0]         bit_cnt;
  logic                  running;
  logic [DIGIT_BITS:0]   trial;
  logic                  ge;
  logic                  last_step;

  // One restoring division step per cycle, quotient bit shifted in at the bottom
  always_comb begin
    trial     = {rem, quo[WIDTH-1]};
    ge        = (trial >= {1'b0, radix});
    rem_next  = ge ? DIGIT_BITS'(trial - {1'b0, radix}) : trial[DIGIT_BITS-1:0];
    quo_next  = {quo[WIDTH-2:0], ge};
    last_step = running && (bit_cnt == BW'(WIDTH - 1));
  end

  assign status.done     = last_step;
  assign status.quo_zero = (quo_next == '0);
  assign status.digit    = rem_next;

  // Advance through the bits; restart on the quotient until it reaches zero
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      bit_cnt <= '0;
    end else if (load) begin
      running <= 1'b1;
      bit_cnt <= '0;
    end else if (running) begin
      if (last_step) begin
        bit_cnt <= '0;
        running <= (quo_next != '0);
      end else begin
        bit_cnt <= bit_cnt + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo <= operand;
      rem <= '0;
    end else if (running) begin
      quo <= quo_next;
      rem <= last_step ? '0 : rem_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/radix_to_ascii_converter.sv =====
// Sequence: a bad radix gives its one result in the cycle after start is taken.
// Otherwise the bit-serial divider (W = min(VALUE_BITS, 32) bits wide) finds each of the
// D digits in turn, then each character is read from the digit store and then emitted.
// busy falls in the cycle that shows the last character; results cannot be stalled.
// Reset (rst, synchronous) clears control state and sets radix to 10.
`default_nettype none
module radix_to_ascii_converter
  import r2a_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FIELD_BITS-1:0] value,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [DIGIT_BITS-1:0] radix,
  output logic                       strobe,
  output logic [CHAR_BITS-1:0]       char_code,
  output logic                       bad_radix,
  output logic                       last_char
);

  localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  conv_state_t           state;
  conv_state_t           state_next;
  logic [DIGIT_BITS-1:0] radix_reg;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [AW-1:0]         ptr;
  logic [AW-1:0]         ptr_next;
  logic                  strobe_next;
  logic [CHAR_BITS-1:0]  char_code_next;
  logic                  bad_radix_next;
  logic                  last_char_next;
  logic                  div_load;
  logic                  wr_en;
  logic                  radix_bad;
  div_status_t           div_st;

  logic [DIGIT_BITS-1:0] digit_mem [VALUE_BITS];
  logic [DIGIT_BITS-1:0] rd_data;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);

  r2a_divider #(
    .WIDTH (VW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .load    (div_load),
    .operand (value[VW-1:0]),
    .radix   (radix_reg),
    .status  (div_st)
  );

  // Hold the radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_reg <= radix;
    end
  end

  // Digit store, least significant digit at the lowest address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[cnt[AW-1:0]] <= div_st.digit;
    end
    rd_data <= digit_mem[ptr];
  end

  // Sequence division, readback and emission
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ptr_next       = ptr;
    strobe_next    = 1'b0;
    char_code_next = char_code;
    bad_radix_next = bad_radix;
    last_char_next = last_char;
    div_load       = 1'b0;
    wr_en          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cnt_next = '0;
          if (radix_bad) begin
            strobe_next    = 1'b1;
            char_code_next = CHAR_NONE;
            bad_radix_next = 1'b1;
            last_char_next = 1'b1;
          end else begin
            div_load   = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          wr_en    = 1'b1;
          cnt_next = cnt + CW'(1);
          if (div_st.quo_zero) begin
            ptr_next   = cnt[AW-1:0];
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_next    = 1'b1;
        char_code_next = digit_to_char(rd_data);
        bad_radix_next = 1'b0;
        last_char_next = (ptr == '0);
        if (ptr == '0) begin
          state_next = ST_IDLE;
        end else begin
          ptr_next   = ptr - AW'(1);
          state_next = ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    char_code <= char_code_next;
    bad_radix <= bad_radix_next;
    last_char <= last_char_next;
  end

endmodule
`default_nettype wire

// ===== hdl/r2a_checker.sv =====
`default_nettype none
module r2a_checker
  import r2a_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  busy,
  input wire logic                  strobe,
  input wire logic [CHAR_BITS-1:0]  char_code,
  input wire logic                  bad_radix,
  input wire logic                  last_char
);

  // An error item is a single zero character that ends the number
  a_bad_item: assert property (@(posedge clk) disable iff (rst)
    strobe && bad_radix |-> (char_code == CHAR_NONE) && last_char)
    else $error("bad radix item malformed");

  // A good item carries a digit or letter character
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe && !bad_radix |->
      ((char_code >= 8'h30) && (char_code <= 8'h39)) ||
      ((char_code >= 8'h41) && (char_code <= 8'h5A)))
    else $error("character out of range");

  // More characters pending keeps the block busy and spaces the items
  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |-> busy ##1 !strobe)
    else $error("non-final character without pending work");

  // Reset leaves no result and an idle block
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("activity right after reset");

endmodule

bind radix_to_ascii_converter r2a_checker u_r2a_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .strobe    (strobe),
  .char_code (char_code),
  .bad_radix (bad_radix),
  .last_char (last_char)
);
`default_nettype wire
